// File: sv/height_gradient_colorizer_defines.svh
// Assertion macros shared by the height gradient colorizer RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef HEIGHT_GRADIENT_COLORIZER_DEFINES_SVH
`define HEIGHT_GRADIENT_COLORIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HGC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HGC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hgc_pkg.sv
// Shared types, constants and helpers for the height gradient colorizer.
// No dependencies; used by hgc_div and height_gradient_colorizer.
package hgc_pkg;

  // Fixed point: weights are Q.16 with 1.0 = 65536.
  localparam int WGT_W = 26;
  localparam logic [WGT_W-1:0] Q_ONE   = 26'd65536;
  localparam logic [WGT_W-1:0] WGT_MAX = 26'h2000000;

  // Pipelined divider geometry.
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 36;
  localparam int DIV_QUO_W  = 32;
  localparam int DIV_SIDE_W = 34;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 3'd4;

  localparam logic [31:0] RST_RANGE_START = 32'h0000_0000;
  localparam logic [31:0] RST_RANGE_END   = 32'h0001_0000;
  localparam logic [31:0] RST_LOW_COLOR   = 32'hFF00_00FF;
  localparam logic [31:0] RST_HIGH_COLOR  = 32'hFFFF_00FF;
  localparam logic [2:0]  RST_BLEND_MODE  = 3'd2;

  // Blend selection carried down the pipeline.
  localparam int SEL_W = 4;
  typedef enum logic [SEL_W-1:0] {
    SEL_NC,
    SEL_SOLID_LO,
    SEL_SOLID_HI,
    SEL_LIN1,
    SEL_LIN2,
    SEL_LIN3,
    SEL_QLO,
    SEL_QHI,
    SEL_ERR
  } sel_t;

  typedef struct packed {
    logic                  valid;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_DEN_W-1:0]  den;
    logic [DIV_SIDE_W-1:0] side;
  } div_req_t;

  typedef struct packed {
    logic                  valid;
    logic                  ovf;
    logic [DIV_QUO_W-1:0]  quo;
    logic [DIV_DEN_W-1:0]  rem;
    logic [DIV_SIDE_W-1:0] side;
  } div_rsp_t;

  // Channel k of a packed RGBA word, red first.
  function automatic logic [7:0] chan8(input logic [31:0] c, input logic [1:0] k);
    logic [7:0] res;
    case (k)
      2'd0:    res = c[31:24];
      2'd1:    res = c[23:16];
      2'd2:    res = c[15:8];
      default: res = c[7:0];
    endcase
    return res;
  endfunction

endpackage

// File: sv/hgc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on hgc_pkg and height_gradient_colorizer_defines.svh.
`include "height_gradient_colorizer_defines.svh"

module hgc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  hgc_pkg::div_req_t   req,
  output hgc_pkg::div_rsp_t   rsp
);

  logic                           vld_r  [0:hgc_pkg::DIV_QUO_W];
  logic                           ovf_r  [0:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_DEN_W:0]    rem_r  [0:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_QUO_W-1:0]  low_r  [0:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_QUO_W-1:0]  quo_r  [0:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_DEN_W-1:0]  den_r  [0:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_SIDE_W-1:0] side_r [0:hgc_pkg::DIV_QUO_W];

  logic [hgc_pkg::DIV_DEN_W:0] shifted [1:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_DEN_W:0] diff    [1:hgc_pkg::DIV_QUO_W];
  logic                        ge      [1:hgc_pkg::DIV_QUO_W];
  logic [hgc_pkg::DIV_DEN_W:0] hi_ext;

  // The upper dividend bits must already be below the divisor, otherwise
  // the quotient does not fit and the overflow flag is raised.
  assign hi_ext = (hgc_pkg::DIV_DEN_W+1)'(req.num[hgc_pkg::DIV_NUM_W-1:hgc_pkg::DIV_QUO_W]);

  always_comb begin
    for (int k = 1; k <= hgc_pkg::DIV_QUO_W; k++) begin
      shifted[k] = {rem_r[k-1][hgc_pkg::DIV_DEN_W-1:0], low_r[k-1][hgc_pkg::DIV_QUO_W-1]};
      ge[k]      = shifted[k] >= {1'b0, den_r[k-1]};
      diff[k]    = shifted[k] - {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= hgc_pkg::DIV_QUO_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= req.valid;
      for (int k = 1; k <= hgc_pkg::DIV_QUO_W; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= hi_ext;
      low_r[0]  <= req.num[hgc_pkg::DIV_QUO_W-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= req.den;
      ovf_r[0]  <= hi_ext >= {1'b0, req.den};
      side_r[0] <= req.side;
      for (int k = 1; k <= hgc_pkg::DIV_QUO_W; k++) begin
        rem_r[k]  <= ge[k] ? diff[k] : shifted[k];
        low_r[k]  <= low_r[k-1] << 1;
        quo_r[k]  <= {quo_r[k-1][hgc_pkg::DIV_QUO_W-2:0], ge[k]};
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign rsp.valid = vld_r[hgc_pkg::DIV_QUO_W];
  assign rsp.ovf   = ovf_r[hgc_pkg::DIV_QUO_W];
  assign rsp.quo   = quo_r[hgc_pkg::DIV_QUO_W];
  assign rsp.rem   = rem_r[hgc_pkg::DIV_QUO_W][hgc_pkg::DIV_DEN_W-1:0];
  assign rsp.side  = side_r[hgc_pkg::DIV_QUO_W];

  `HGC_ASSERT_IMPL(a_rem_below_den, rsp.valid && !rsp.ovf, rem_r[hgc_pkg::DIV_QUO_W] < {1'b0, den_r[hgc_pkg::DIV_QUO_W]}, "divider remainder not below divisor")
  `HGC_ASSERT_NEXT(a_first_advance, en && vld_r[0], vld_r[1], "divider lost a request between its first stages")
  `HGC_ASSERT_NEXT(a_out_hold, !en && vld_r[hgc_pkg::DIV_QUO_W], vld_r[hgc_pkg::DIV_QUO_W] && $stable(quo_r[hgc_pkg::DIV_QUO_W]), "divider output changed while stalled")

endmodule

// File: sv/height_gradient_colorizer.sv
// Height gradient colorizer: maps a Q16.16 height to an RGBA color.
// The pipe is two 33-stage bit-per-stage dividers plus eight other register
// stages.
// Throughput is one request per cycle while not stalled; one global stall freezes all stages.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// Depends on hgc_pkg, hgc_div and height_gradient_colorizer_defines.svh.
`include "height_gradient_colorizer_defines.svh"

module height_gradient_colorizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [hgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic                            out_range_error
);

  // Signed working width for heights, their sums and doubled sums.
  localparam int CW = 37;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is
  // empty; the block does not enforce it. Each stage reads them directly, no snapshot.
  // ---------------------------------------------------------------------------
  logic signed [31:0] range_start_r;
  logic signed [31:0] range_end_r;
  logic [31:0]        low_color_r;
  logic [31:0]        high_color_r;
  logic [2:0]         blend_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= hgc_pkg::RST_RANGE_START;
      range_end_r   <= hgc_pkg::RST_RANGE_END;
      low_color_r   <= hgc_pkg::RST_LOW_COLOR;
      high_color_r  <= hgc_pkg::RST_HIGH_COLOR;
      blend_mode_r  <= hgc_pkg::RST_BLEND_MODE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hgc_pkg::REG_RANGE_START: range_start_r <= cfg_wdata;
        hgc_pkg::REG_RANGE_END:   range_end_r   <= cfg_wdata;
        hgc_pkg::REG_LOW_COLOR:   low_color_r   <= cfg_wdata;
        hgc_pkg::REG_HIGH_COLOR:  high_color_r  <= cfg_wdata;
        hgc_pkg::REG_BLEND_MODE:  blend_mode_r  <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Values derived from configuration. In cyclic mode the whole problem is
  // mirrored when the period S = start + end is negative, so that the period
  // sm, the split point fm and the upper part tm all work with S > 0.
  // ---------------------------------------------------------------------------
  logic               cyclic;
  logic               linear;
  logic               sharp;
  logic signed [CW-1:0] f_x, t_x, s_x, d_x;
  logic               s_neg, d_neg, cfg_err;
  logic signed [CW-1:0] sm_x, fm_x, tm_x, dabs_x, k_seg3, k_qhi;
  logic [31:0]        avg_color;

  assign cyclic = blend_mode_r[0];
  assign linear = blend_mode_r[1];
  assign sharp  = blend_mode_r[2];

  assign f_x    = CW'(range_start_r);
  assign t_x    = CW'(range_end_r);
  assign s_x    = f_x + t_x;
  assign d_x    = t_x - f_x;
  assign s_neg  = s_x < 0;
  assign d_neg  = d_x < 0;
  assign sm_x   = s_neg ? -s_x : s_x;
  assign fm_x   = s_neg ? -f_x : f_x;
  assign tm_x   = sm_x - fm_x;
  assign dabs_x = d_neg ? -d_x : d_x;
  assign k_seg3 = sm_x + fm_x;
  assign k_qhi  = sm_x - fm_x - (fm_x <<< 1);
  assign cfg_err = cyclic ? (s_x == 0) : (d_x == 0);

  // The average color halves each channel before adding, so it never carries.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      avg_color[8*(3-k) +: 8] = (hgc_pkg::chan8(low_color_r, 2'(k)) >> 1)
                              + (hgc_pkg::chan8(high_color_r, 2'(k)) >> 1);
    end
  end

  // ---------------------------------------------------------------------------
  // One stall signal for the whole pipe: everything advances unless the output
  // register holds a result the consumer has not taken yet.
  // ---------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: input request register.
  logic               v1_r;
  logic signed [31:0] h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) h_r <= in_height;
  end

  // Stage 2 logic: build the modulo request. The divider sees |h| over the
  // positive period; the sign of the mirrored height rides along so the floor
  // remainder can be fixed up afterwards. The non-cyclic numerator is clamped
  // to 0..D here, which is exactly the clamp of v to 0..1.
  logic signed [CW-1:0] h_x, habs_x, nh_x, nhn_x, n_nc_x, ncn_x;
  logic                 hneg;
  hgc_pkg::div_req_t    req1;
  hgc_pkg::div_rsp_t    rsp1;

  assign h_x    = CW'(h_r);
  assign habs_x = (h_x < 0) ? -h_x : h_x;
  assign hneg   = s_neg ? (h_x > 0) : (h_x < 0);
  assign nh_x   = h_x - f_x;
  assign nhn_x  = f_x - h_x;
  assign n_nc_x = d_neg ? nhn_x : nh_x;
  assign ncn_x  = (n_nc_x < 0) ? '0 : ((n_nc_x > dabs_x) ? dabs_x : n_nc_x);

  assign req1.valid = v1_r;
  assign req1.num   = {32'd0, habs_x[31:0]};
  assign req1.den   = sm_x[hgc_pkg::DIV_DEN_W-1:0];
  assign req1.side  = {hneg, ncn_x[32:0]};

  hgc_div u_mod_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (req1),
    .rsp   (rsp1)
  );

  // Stage 4: floor remainder r' in 0..sm-1.
  logic        v4_r;
  logic [32:0] rp_r;
  logic [32:0] ncn_r;
  logic signed [CW-1:0] rem1_x, rp_x4;

  assign rem1_x = CW'({1'b0, rsp1.rem});
  assign rp_x4  = (rsp1.side[33] && (rsp1.rem != '0)) ? (sm_x - rem1_x) : rem1_x;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= rsp1.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r  <= rp_x4[32:0];
      ncn_r <= rsp1.side[32:0];
    end
  end

  // Stage 5: pick the segment and form the weight division N2 / D2. Every
  // rounded ratio is floor((2*N2*65536 + D2) / (2*D2)) with N2 >= 0. For the
  // parabola the signed argument is biased by one so that N2 stays positive.
  logic        v5_r;
  logic [34:0] n2_r;
  logic [33:0] d2_r;
  hgc_pkg::sel_t sel5_r;

  logic signed [CW-1:0] rp_x, rp2_x, n2_x, d2_x;
  logic                 below, seg1, seg2;
  hgc_pkg::sel_t        sel5;

  assign rp_x  = CW'({1'b0, rp_r});
  assign rp2_x = rp_x <<< 1;
  assign below = rp_x < fm_x;
  assign seg1  = rp2_x < fm_x;
  assign seg2  = rp2_x < k_seg3;

  always_comb begin
    sel5 = hgc_pkg::SEL_ERR;
    n2_x = '0;
    d2_x = CW'(1);
    if (cfg_err) begin
      sel5 = hgc_pkg::SEL_ERR;
    end else if (!cyclic) begin
      sel5 = hgc_pkg::SEL_NC;
      n2_x = CW'({1'b0, ncn_r});
      d2_x = dabs_x;
    end else if (sharp) begin
      sel5 = below ? hgc_pkg::SEL_SOLID_LO : hgc_pkg::SEL_SOLID_HI;
    end else if (linear) begin
      if (seg1) begin
        sel5 = hgc_pkg::SEL_LIN1;
        n2_x = rp_x;
        d2_x = sm_x;
      end else if (seg2) begin
        sel5 = hgc_pkg::SEL_LIN2;
        n2_x = rp2_x - fm_x;
        d2_x = sm_x <<< 1;
      end else begin
        sel5 = hgc_pkg::SEL_LIN3;
        n2_x = rp2_x - k_seg3;
        d2_x = sm_x <<< 1;
      end
    end else if (below) begin
      sel5 = hgc_pkg::SEL_QLO;
      n2_x = rp2_x + fm_x;
      d2_x = fm_x <<< 1;
    end else begin
      sel5 = hgc_pkg::SEL_QHI;
      n2_x = rp2_x + k_qhi;
      d2_x = tm_x <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r   <= n2_x[34:0];
      d2_r   <= d2_x[33:0];
      sel5_r <= sel5;
    end
  end

  // Stage 6: register the rounded-division operands.
  logic                             v6_r;
  logic [hgc_pkg::DIV_NUM_W-1:0]    num6_r;
  logic [hgc_pkg::DIV_DEN_W-1:0]    den6_r;
  hgc_pkg::sel_t                    sel6_r;
  logic [hgc_pkg::DIV_NUM_W-1:0]    num6;

  assign num6 = (hgc_pkg::DIV_NUM_W'(n2_r) << 17) + hgc_pkg::DIV_NUM_W'(d2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num6_r <= num6;
      den6_r <= {1'b0, d2_r, 1'b0};
      sel6_r <= sel5_r;
    end
  end

  hgc_pkg::div_req_t req2;
  hgc_pkg::div_rsp_t rsp2;

  assign req2.valid = v6_r;
  assign req2.num   = num6_r;
  assign req2.den   = den6_r;
  assign req2.side  = hgc_pkg::DIV_SIDE_W'(sel6_r);

  hgc_div u_wgt_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (req2),
    .rsp   (rsp2)
  );

  // Stage 7: clamp the weight (anything from 512.0 up saturates a channel
  // anyway) and square the parabola argument x = q - 1.0.
  logic                         v7_r;
  logic [hgc_pkg::WGT_W-1:0]    wq_r;
  logic [35:0]                  xsq_r;
  hgc_pkg::sel_t                sel7_r;

  hgc_pkg::sel_t                sel7;
  logic [hgc_pkg::WGT_W-1:0]    wq7;
  logic signed [18:0]           x7;
  logic signed [37:0]           xsq7;

  assign sel7 = hgc_pkg::sel_t'(rsp2.side[hgc_pkg::SEL_W-1:0]);
  assign wq7  = (rsp2.ovf || (rsp2.quo > 32'(hgc_pkg::WGT_MAX))) ? hgc_pkg::WGT_MAX
                                                               : rsp2.quo[hgc_pkg::WGT_W-1:0];
  assign x7   = $signed({1'b0, rsp2.quo[17:0]}) - 19'sd65536;
  assign xsq7 = x7 * x7;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= rsp2.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wq_r   <= wq7;
      xsq_r  <= xsq7[35:0];
      sel7_r <= sel7;
    end
  end

  // Stage 8: round the parabola weight and choose the two colors and weights.
  // A solid color is a blend with weight 1.0 on one side and 0 on the other.
  logic                         v8_r;
  logic                         err8_r;
  logic [31:0]                  ca_r, cb_r;
  logic [hgc_pkg::WGT_W-1:0]    wa_r, wb_r;

  logic [36:0]                  usum;
  logic [22:0]                  ubig;
  logic [hgc_pkg::WGT_W-1:0]    u8, ucomp, wcomp;
  logic [31:0]                  ca8, cb8;
  logic [hgc_pkg::WGT_W-1:0]    wa8, wb8;

  assign usum  = {1'b0, xsq_r} + 37'd8192;
  assign ubig  = usum[36:14];
  assign u8    = (ubig > 23'(hgc_pkg::Q_ONE)) ? hgc_pkg::Q_ONE : {3'b0, ubig};
  assign ucomp = hgc_pkg::Q_ONE - u8;
  assign wcomp = (wq_r >= hgc_pkg::Q_ONE) ? '0 : (hgc_pkg::Q_ONE - wq_r);

  always_comb begin
    ca8 = low_color_r;
    cb8 = high_color_r;
    wa8 = '0;
    wb8 = '0;
    case (sel7_r)
      hgc_pkg::SEL_NC: begin
        ca8 = low_color_r;  wa8 = wcomp;
        cb8 = high_color_r; wb8 = wq_r;
      end
      hgc_pkg::SEL_SOLID_LO: begin
        ca8 = low_color_r;  wa8 = hgc_pkg::Q_ONE;
      end
      hgc_pkg::SEL_SOLID_HI: begin
        ca8 = high_color_r; wa8 = hgc_pkg::Q_ONE;
      end
      hgc_pkg::SEL_LIN1: begin
        ca8 = avg_color;    wa8 = wcomp;
        cb8 = low_color_r;  wb8 = wq_r;
      end
      hgc_pkg::SEL_LIN2: begin
        ca8 = low_color_r;  wa8 = wcomp;
        cb8 = high_color_r; wb8 = wq_r;
      end
      hgc_pkg::SEL_LIN3: begin
        ca8 = high_color_r; wa8 = wcomp;
        cb8 = avg_color;    wb8 = wq_r;
      end
      hgc_pkg::SEL_QLO: begin
        ca8 = low_color_r;  wa8 = ucomp;
        cb8 = avg_color;    wb8 = u8;
      end
      hgc_pkg::SEL_QHI: begin
        ca8 = avg_color;    wa8 = u8;
        cb8 = high_color_r; wb8 = ucomp;
      end
      default: begin
        wa8 = '0;
        wb8 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r   <= ca8;
      cb_r   <= cb8;
      wa_r   <= wa8;
      wb_r   <= wb8;
      err8_r <= (sel7_r == hgc_pkg::SEL_ERR);
    end
  end

  // Stage 9: eight channel-by-weight products.
  logic        v9_r;
  logic        err9_r;
  logic [33:0] pa_r [0:3];
  logic [33:0] pb_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err9_r <= err8_r;
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= 34'(hgc_pkg::chan8(ca_r, 2'(k))) * 34'(wa_r);
        pb_r[k] <= 34'(hgc_pkg::chan8(cb_r, 2'(k))) * 34'(wb_r);
      end
    end
  end

  // Stage 10: round each product to 8 bits, saturate, add and saturate again; a range error forces zero.
  logic [33:0] ra    [0:3];
  logic [33:0] rb    [0:3];
  logic [7:0]  sa    [0:3];
  logic [7:0]  sb    [0:3];
  logic [8:0]  ssum  [0:3];
  logic [7:0]  res   [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ra[k]   = pa_r[k] + 34'd32768;
      rb[k]   = pb_r[k] + 34'd32768;
      sa[k]   = (|ra[k][33:24]) ? 8'hFF : ra[k][23:16];
      sb[k]   = (|rb[k][33:24]) ? 8'hFF : rb[k][23:16];
      ssum[k] = {1'b0, sa[k]} + {1'b0, sb[k]};
      res[k]  = ssum[k][8] ? 8'hFF : ssum[k][7:0];
      if (err9_r) res[k] = '0;
    end
  end

  logic [7:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic       out_range_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v9_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red_r         <= res[0];
      out_green_r       <= res[1];
      out_blue_r        <= res[2];
      out_alpha_r       <= res[3];
      out_range_error_r <= err9_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;
  assign out_range_error = out_range_error_r;

  // A range error must always come with an all-zero color.
  `HGC_ASSERT_IMPL(a_err_zero, out_valid_r && out_range_error_r, out_red_r == 8'd0 && out_green_r == 8'd0 && out_blue_r == 8'd0 && out_alpha_r == 8'd0, "range error with nonzero color")
  // The biased parabola argument must land in 0.5..1.5.
  `HGC_ASSERT_IMPL(a_quad_span, rsp2.valid && (sel7 == hgc_pkg::SEL_QLO || sel7 == hgc_pkg::SEL_QHI), !rsp2.ovf && rsp2.quo >= 32'd32768 && rsp2.quo <= 32'd98304, "parabola argument out of range")
  // The clamped non-cyclic ratio can never exceed 1.0.
  `HGC_ASSERT_IMPL(a_nc_span, rsp2.valid && sel7 == hgc_pkg::SEL_NC, !rsp2.ovf && rsp2.quo <= 32'd65536, "non-cyclic weight above one")

endmodule
